// ===== rtl/lfb_pkg.sv =====
// Shared types and constants for the link failover backoff timer.
package lfb_pkg;

  localparam int unsigned MAX_NETS_DEFAULT = 8;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned NET_W    = 4;
  localparam int unsigned DWELL_W  = 20;
  localparam int unsigned CFG_DW   = 20;

  localparam logic [NET_W-1:0]        NET_COUNT_RESET = 4'd1;
  localparam logic signed [NET_W-1:0] INIT_NET_RESET  = -4'sd1;
  localparam logic [DWELL_W-1:0]      DWELL_MIN_RESET = 20'd120000;
  localparam logic [DWELL_W-1:0]      DWELL_MAX_RESET = 20'd600000;

  typedef enum logic [1:0] {
    CFG_NET_COUNT = 2'd0,
    CFG_INIT_NET  = 2'd1,
    CFG_DWELL_MIN = 2'd2,
    CFG_DWELL_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              we;
    cfg_reg_t          index;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
  } in_item_t;

  typedef struct packed {
    logic                     rotate;
    logic signed [NET_W-1:0]  network_index;
    logic [TIME_W-1:0]        disconnect_total;
    logic [TIME_W-1:0]        up_ms;
    logic [TIME_W-1:0]        down_ms;
  } out_item_t;

endpackage

// ===== rtl/lfb_if.sv =====
// Valid/ready channel interfaces for poll ticks and timer results.
interface lfb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        link_up;

  modport source (output valid, output now_ms, output link_up, input ready);
  modport sink (input valid, input now_ms, input link_up, output ready);
endinterface

interface lfb_out_if;
  logic              valid;
  logic              ready;
  logic              rotate;
  logic signed [3:0] network_index;
  logic [31:0]       disconnect_total;
  logic [31:0]       up_ms;
  logic [31:0]       down_ms;

  modport source (output valid, output rotate, output network_index,
                  output disconnect_total, output up_ms, output down_ms, input ready);
  modport sink (input valid, input rotate, input network_index,
                input disconnect_total, input up_ms, input down_ms, output ready);
endinterface

// ===== rtl/link_failover_backoff_timer.sv =====
// Top level of the link failover backoff timer: tick register, core and result register.
//
// Usage:
//   in_ch carries one poll tick per transfer: now_ms (free-running ms time) and
//   link_up. out_ch carries exactly one result per tick: rotate, network_index,
//   disconnect_total, up_ms and down_ms, in tick order.
//   cfg_we/cfg_index/cfg_wdata write net_count, initial_network, dwell_min_ms and
//   dwell_max_ms; write only while no tick is in flight.
// Stages: two register stages, the tick register and then the result register,
//   which takes the core's result for the held tick.
// Throughput: one tick per cycle while out_ch takes results; the link state update
//   is logic (compares, 32-bit adds, a small index wrap) around the state registers.
// Reset (rst_n low at a clock edge): both stages empty, registers back to their
//   defaults, link state cleared, current network = -1, dwell = 120000 ms.
// Stall: while out_ch is not ready the result is held; the tick register still
//   takes one more tick, then in_ch.ready drops until the result register drains.
module link_failover_backoff_timer import lfb_pkg::*; #(
  parameter int unsigned MAX_NETS = MAX_NETS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  lfb_in_if.sink             in_ch,
  lfb_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_item_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r;
  out_item_t core_res;
  cfg_wr_t   cfg_wr;
  logic      in_xfer;
  logic      adv;

  // Advance the held tick whenever the result register is empty or draining.
  assign adv       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_xfer   = in_ch.valid && in_ch.ready;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_reg_t'(cfg_index);
  assign cfg_wr.data  = cfg_wdata;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture the tick and the finished result; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.now_ms  <= in_ch.now_ms;
      s1_item_r.link_up <= in_ch.link_up;
    end
    if (adv) begin
      out_item_r <= core_res;
    end
  end

  lfb_core #(
    .MAX_NETS (MAX_NETS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .step   (adv),
    .item   (s1_item_r),
    .result (core_res)
  );

  assign out_ch.valid            = out_v_r;
  assign out_ch.rotate           = out_item_r.rotate;
  assign out_ch.network_index    = out_item_r.network_index;
  assign out_ch.disconnect_total = out_item_r.disconnect_total;
  assign out_ch.up_ms            = out_item_r.up_ms;
  assign out_ch.down_ms          = out_item_r.down_ms;

`ifndef ASSERT_OFF
  // A rotation always lands on a real network index.
  a_rotate_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rotate) |-> !out_ch.network_index[3])
    else $error("rotate with negative network index");

  // A rotation only happens on a down tick, so no uptime is reported with it.
  a_rotate_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.rotate) |-> (out_ch.up_ms == '0))
    else $error("rotate reported while link up");

  // A held tick is never dropped while the result register is blocked.
  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("held tick lost");
`endif

endmodule

// ===== rtl/lfb_core.sv =====
// Configuration registers, link state and per-tick update logic.
module lfb_core import lfb_pkg::*; #(
  parameter int unsigned MAX_NETS = MAX_NETS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg_wr,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic [NET_W:0] MaxNetsW = (NET_W+1)'(MAX_NETS);

  logic [NET_W-1:0]        net_count_r;
  logic [DWELL_W-1:0]      dwell_min_r;
  logic [DWELL_W-1:0]      dwell_max_r;

  logic [TIME_W-1:0]       up_time_r, up_time_nxt;
  logic [TIME_W-1:0]       down_time_r, down_time_nxt;
  logic [TIME_W-1:0]       drop_cnt_r, drop_cnt_nxt;
  logic signed [NET_W-1:0] cur_net_r, cur_net_nxt;
  logic [DWELL_W-1:0]      dwell_r, dwell_nxt;
  logic [TIME_W-1:0]       deadline_r, deadline_nxt;

  logic [TIME_W-1:0]  now_nz;
  logic [TIME_W-1:0]  now_minus_dl;
  logic [NET_W:0]     cnt_sat;
  logic [NET_W-1:0]   net_cnt;
  logic               arm;
  logic               passed;
  logic               rot;
  logic [DWELL_W:0]   dwell_dbl;
  logic [DWELL_W-1:0] dwell_new;
  logic [NET_W-1:0]   net_step;

  // Reduce a small value modulo the count by repeated subtraction.
  function automatic logic [NET_W-1:0] wrap_net(input logic [NET_W-1:0] v,
                                                 input logic [NET_W-1:0] c);
    logic [NET_W-1:0] acc;
    acc = v;
    for (int i = 0; i < 4; i++) begin
      if (acc >= c) begin
        acc = acc - c;
      end
    end
    return acc;
  endfunction

  always_comb begin
    now_nz       = (item.now_ms == '0) ? TIME_W'(1) : item.now_ms;
    cnt_sat      = ({1'b0, net_count_r} > MaxNetsW) ? MaxNetsW : {1'b0, net_count_r};
    net_cnt      = cnt_sat[NET_W-1:0];
    arm          = (down_time_r == '0);
    now_minus_dl = item.now_ms - deadline_r;
    // A freshly armed deadline has already passed only for a zero dwell.
    passed       = arm ? (dwell_r == '0) : !now_minus_dl[TIME_W-1];
    rot          = !item.link_up && (net_cnt > NET_W'(1)) && passed;

    dwell_dbl = (dwell_r < dwell_max_r) ? {dwell_r, 1'b0} : {1'b0, dwell_r};
    dwell_new = (dwell_dbl > {1'b0, dwell_max_r}) ? dwell_max_r : dwell_dbl[DWELL_W-1:0];

    net_step = cur_net_r[NET_W-1] ? '0
             : wrap_net({1'b0, cur_net_r[NET_W-2:0]} + NET_W'(1), net_cnt);

    up_time_nxt   = up_time_r;
    down_time_nxt = down_time_r;
    drop_cnt_nxt  = drop_cnt_r;
    cur_net_nxt   = cur_net_r;
    dwell_nxt     = dwell_r;
    deadline_nxt  = deadline_r;

    if (item.link_up) begin
      if (up_time_r == '0) begin
        up_time_nxt = now_nz;
      end
      down_time_nxt = '0;
      dwell_nxt     = dwell_min_r;
    end else begin
      up_time_nxt = '0;
      if (up_time_r != '0) begin
        drop_cnt_nxt = drop_cnt_r + TIME_W'(1);
      end
      if (arm) begin
        down_time_nxt = now_nz;
        deadline_nxt  = item.now_ms + TIME_W'(dwell_r);
      end
      if (rot) begin
        cur_net_nxt  = $signed(net_step);
        dwell_nxt    = dwell_new;
        deadline_nxt = item.now_ms + TIME_W'(dwell_new);
      end
    end

    result.rotate           = rot;
    result.network_index    = cur_net_nxt;
    result.disconnect_total = drop_cnt_nxt;
    result.up_ms            = (up_time_nxt != '0) ? item.now_ms - up_time_nxt : '0;
    result.down_ms          = (down_time_nxt != '0) ? item.now_ms - down_time_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_count_r <= NET_COUNT_RESET;
      dwell_min_r <= DWELL_MIN_RESET;
      dwell_max_r <= DWELL_MAX_RESET;
      up_time_r   <= '0;
      down_time_r <= '0;
      drop_cnt_r  <= '0;
      cur_net_r   <= INIT_NET_RESET;
      dwell_r     <= DWELL_MIN_RESET;
      deadline_r  <= '0;
    end else begin
      if (step) begin
        up_time_r   <= up_time_nxt;
        down_time_r <= down_time_nxt;
        drop_cnt_r  <= drop_cnt_nxt;
        cur_net_r   <= cur_net_nxt;
        dwell_r     <= dwell_nxt;
        deadline_r  <= deadline_nxt;
      end
      if (cfg_wr.we) begin
        case (cfg_wr.index)
          CFG_NET_COUNT: net_count_r <= cfg_wr.data[NET_W-1:0];
          // The start network only matters as the load value of the current one.
          CFG_INIT_NET:  cur_net_r   <= $signed(cfg_wr.data[NET_W-1:0]);
          CFG_DWELL_MIN: begin
            dwell_min_r <= cfg_wr.data[DWELL_W-1:0];
            dwell_r     <= cfg_wr.data[DWELL_W-1:0];
          end
          CFG_DWELL_MAX: dwell_max_r <= cfg_wr.data[DWELL_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/link_failover_backoff_timer_test.sv =====
// Self-checking test of the link failover backoff timer: directed rows, then random poll runs.
module link_failover_backoff_timer_test import lfb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_NETS = MAX_NETS_DEFAULT;
  localparam int          PERIOD   = 12;
  // Tick register plus result register: two stages between the channels.
  localparam int          LATENCY  = 2;
  localparam int          PHASES   = 16;
  localparam int          PHASE_POLLS = 80;
  localparam int          LONG_HOLD = 64;

  typedef enum {ROW_WRITE, ROW_POLL, ROW_POLL_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          reg_sel;
    logic [CFG_DW-1:0] wdata;
    logic [31:0]       now;
    logic              up;
    out_item_t         known;
  } dir_row_t;

  localparam out_item_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  lfb_in_if  in_ch ();
  lfb_out_if out_ch ();

  link_failover_backoff_timer #(.MAX_NETS(MAX_NETS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Mirror of the register file.
  logic [3:0]         cfg_net_count;
  logic signed [3:0]  cfg_init_net;
  logic [DWELL_W-1:0] cfg_dwell_min;
  logic [DWELL_W-1:0] cfg_dwell_max;

  // Mirror of the link state.
  logic [31:0] up_stamp;
  logic [31:0] down_stamp;
  logic [31:0] drop_tally;
  int          net_sel;
  logic [31:0] dwell_cur;
  logic [31:0] rotate_due;

  // Timer reports still owed by the block, oldest first.
  out_item_t pending_reports[$];

  int mismatches = 0;
  int reports_seen = 0;

  // Idling controls: calm turns off random gaps on both sides; a bump of
  // hold_requests asks the receiver for one long hold-off.
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // Directed rows. Expected reports are typed in only where they are plain
  // from the rules; the rest go through the predictor.
  dir_row_t directed_rows [35] = '{
    // Defaults after reset: time zero on an up tick stores 1, so uptime wraps.
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd0, 1'b1,
      '{1'b0, -4'sd1, 32'd0, 32'hFFFF_FFFF, 32'd0}},
    // First drop counts, single network never rotates.
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd100, 1'b0,
      '{1'b0, -4'sd1, 32'd1, 32'd0, 32'd0}},
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'hFFFF_FFFF, 1'b0,
      '{1'b0, -4'sd1, 32'd1, 32'd0, 32'hFFFF_FF9B}},
    '{ROW_WRITE, CFG_NET_COUNT, 20'd3, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_INIT_NET, 20'hF, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MIN, 20'd10, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MAX, 20'd40, 32'd0, 1'b0, NO_RES},
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd1000, 1'b1,
      '{1'b0, -4'sd1, 32'd1, 32'd0, 32'd0}},
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd2000, 1'b0,
      '{1'b0, -4'sd1, 32'd2, 32'd0, 32'd0}},
    // Deadline reached exactly: none selected goes to network 0.
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd2010, 1'b0,
      '{1'b1, 4'sd0, 32'd2, 32'd0, 32'd10}},
    // Dwell doubles into the ceiling, index wraps modulo the count.
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd2030, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd2070, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd2110, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd2111, 1'b0, NO_RES},
    // Count above the maximum saturates; zero dwell rotates on down ticks, but not on one whose time steps back.
    '{ROW_WRITE, CFG_NET_COUNT, 20'd15, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_INIT_NET, 20'd7, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MIN, 20'd0, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MAX, 20'hFFFFF, 32'd0, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd5000, 1'b1, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd5001, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd5001, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd0, 1'b0, NO_RES},
    // Zero networks, most negative index, dwell above its ceiling.
    '{ROW_WRITE, CFG_NET_COUNT, 20'd0, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_INIT_NET, 20'd8, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MIN, 20'hFFFFF, 32'd0, 1'b0, NO_RES},
    '{ROW_WRITE, CFG_DWELL_MAX, 20'd1, 32'd0, 1'b0, NO_RES},
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, -4'sd8, 32'd3, 32'd0, 32'd0}},
    // Time zero on a down tick stores 1, so downtime wraps.
    '{ROW_POLL_KNOWN, CFG_NET_COUNT, 20'd0, 32'd0, 1'b0,
      '{1'b0, -4'sd8, 32'd4, 32'd0, 32'hFFFF_FFFF}},
    '{ROW_WRITE, CFG_NET_COUNT, 20'd2, 32'd0, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'h8000_0000, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'h8010_0000, 1'b0, NO_RES},
    // Index at or above the count.
    '{ROW_WRITE, CFG_INIT_NET, 20'd6, 32'd0, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'h8010_0001, 1'b0, NO_RES},
    // Deadline compare across the 32-bit wrap.
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd5, 1'b0, NO_RES},
    '{ROW_POLL, CFG_NET_COUNT, 20'd0, 32'd6, 1'b1, NO_RES}
  };

  // Advance the mirrored link state by one poll and return its report.
  function automatic out_item_t poll_timer(logic [31:0] now, logic up);
    out_item_t   res;
    int          count;
    logic [31:0] d;
    logic [31:0] lag;
    res = '0;
    if (up) begin
      if (up_stamp == 32'd0) up_stamp = (now == 32'd0) ? 32'd1 : now;
      down_stamp = 32'd0;
      dwell_cur  = {12'd0, cfg_dwell_min};
    end else begin
      count = (cfg_net_count > MAX_NETS) ? MAX_NETS : int'(cfg_net_count);
      if (up_stamp != 32'd0) begin
        up_stamp   = 32'd0;
        drop_tally = drop_tally + 32'd1;
      end
      if (down_stamp == 32'd0) begin
        down_stamp = (now == 32'd0) ? 32'd1 : now;
        rotate_due = now + dwell_cur;
      end
      lag = now - rotate_due;
      if (count > 1 && !lag[31]) begin
        // Any negative index starts over at network 0.
        net_sel = (net_sel < 0) ? 0 : (net_sel + 1) % count;
        d = dwell_cur;
        if (d < {12'd0, cfg_dwell_max}) d = d << 1;
        if (d > {12'd0, cfg_dwell_max}) d = {12'd0, cfg_dwell_max};
        dwell_cur  = {12'd0, d[DWELL_W-1:0]};
        rotate_due = now + dwell_cur;
        res.rotate = 1'b1;
      end
    end
    res.network_index    = net_sel[3:0];
    res.disconnect_total = drop_tally;
    res.up_ms            = (up_stamp != 32'd0) ? now - up_stamp : 32'd0;
    res.down_ms          = (down_stamp != 32'd0) ? now - down_stamp : 32'd0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] report %0d %s: got %0h, expected %0h", $time, reports_seen, what, got,
             want);
    mismatches++;
  endtask

  // Offer one poll, wait for its transfer and queue its predicted report.
  // Called at a rising edge; returns at the edge of the transfer with valid
  // still high, so a following poll can go out without a bubble.
  task automatic send_poll(logic [31:0] now, logic up, bit known, out_item_t known_res);
    out_item_t res;
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 13);
    end
    in_ch.valid   <= 1'b1;
    in_ch.now_ms  <= now;
    in_ch.link_up <= up;
    do @(posedge clk); while (!in_ch.ready);
    res = poll_timer(now, up);
    pending_reports.push_back(known ? known_res : res);
  endtask

  // Write one register once the block has drained every report.
  task automatic write_reg(cfg_reg_t sel, logic [CFG_DW-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Let the result register settle before touching the registers.
    repeat (LATENCY + 1) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_NET_COUNT: cfg_net_count = value[3:0];
      CFG_INIT_NET: begin
        // Loading the start network also moves the current one.
        cfg_init_net = value[3:0];
        net_sel      = int'(cfg_init_net);
      end
      CFG_DWELL_MIN: begin
        cfg_dwell_min = value[DWELL_W-1:0];
        dwell_cur     = {12'd0, cfg_dwell_min};
      end
      CFG_DWELL_MAX: cfg_dwell_max = value[DWELL_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off on request so the tick
  // register fills and the block drops in_ch.ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Checker: compare every report transfer with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected report", out_ch.down_ms, 32'd0);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.rotate !== want.rotate)
          report_mismatch("rotate", 32'(out_ch.rotate), 32'(want.rotate));
        if (out_ch.network_index !== want.network_index)
          report_mismatch("network_index", 32'(out_ch.network_index),
                          32'(want.network_index));
        if (out_ch.disconnect_total !== want.disconnect_total)
          report_mismatch("disconnect_total", out_ch.disconnect_total,
                          want.disconnect_total);
        if (out_ch.up_ms !== want.up_ms)
          report_mismatch("up_ms", out_ch.up_ms, want.up_ms);
        if (out_ch.down_ms !== want.down_ms)
          report_mismatch("down_ms", out_ch.down_ms, want.down_ms);
      end
    end
  end

  // Stimulus.
  initial begin
    logic [31:0]       now;
    logic              up;
    logic              link;
    int                run_left;
    int                step_cap;
    int                pick;
    logic [CFG_DW-1:0] value;
    cfg_reg_t          sel;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_NET_COUNT;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.now_ms  <= '0;
    in_ch.link_up <= 1'b0;

    // Power-on contents of the registers and the link state.
    cfg_net_count = NET_COUNT_RESET;
    cfg_init_net  = INIT_NET_RESET;
    cfg_dwell_min = DWELL_MIN_RESET;
    cfg_dwell_max = DWELL_MAX_RESET;
    up_stamp      = '0;
    down_stamp    = '0;
    drop_tally    = '0;
    net_sel       = int'(INIT_NET_RESET);
    dwell_cur     = {12'd0, DWELL_MIN_RESET};
    rotate_due    = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE:      write_reg(directed_rows[i].reg_sel, directed_rows[i].wdata);
        ROW_POLL:       send_poll(directed_rows[i].now, directed_rows[i].up, 1'b0, NO_RES);
        ROW_POLL_KNOWN: send_poll(directed_rows[i].now, directed_rows[i].up, 1'b1,
                                  directed_rows[i].known);
        default: ;
      endcase
    end

    // Random phases: fresh settings, then link runs with random content.
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int k = 0; k < 4; k++) begin
        sel = cfg_reg_t'(k);
        if (phase == 0 || $urandom_range(0, 3) != 0) begin
          case (sel)
            CFG_NET_COUNT:
              value = CFG_DW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(2, MAX_NETS));
            CFG_INIT_NET: value = CFG_DW'($urandom_range(0, 15));
            default: begin
              // Mostly short dwells so deadlines pass often; now and then the
              // extremes or a full-width value.
              pick = $urandom_range(0, 7);
              if (pick == 0)      value = '0;
              else if (pick == 1) value = 20'hFFFFF;
              else if (pick == 2) value = CFG_DW'($urandom());
              else                value = CFG_DW'($urandom_range(1, 64));
            end
          endcase
          write_reg(sel, value);
        end
      end

      // Hold the receiver off for a long stretch once, and keep one phase
      // free of any idling.
      if (phase == 2) hold_requests <= hold_requests + 1;
      calm <= (phase == 5);

      step_cap = (cfg_dwell_max > cfg_dwell_min) ? int'(cfg_dwell_max) : int'(cfg_dwell_min);
      now      = $urandom();
      link     = 1'($urandom_range(0, 1));
      run_left = 0;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (run_left == 0) begin
          link     = !link;
          run_left = link ? $urandom_range(1, 4) : $urandom_range(1, 24);
        end
        run_left--;
        pick = $urandom_range(0, 99);
        if (pick < 4)      now = $urandom();
        else if (pick < 6) now = '0;
        else               now = now + $urandom_range(0, step_cap + 2);
        // Flip the link for a single poll now and then to break the runs.
        up = ($urandom_range(0, 99) < 8) ? !link : link;
        send_poll(now, up, 1'b0, NO_RES);
      end
    end

    // Drain: stop offering, wait for every report, then a few more cycles
    // to catch anything extra.
    in_ch.valid <= 1'b0;
    calm <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("link_failover_backoff_timer_test: PASS");
    end else begin
      $display("link_failover_backoff_timer_test: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(2_000_000);
    $display("link_failover_backoff_timer_test: FAIL");
    $finish;
  end

endmodule

// ===== link_failover_backoff_timer.f =====
rtl/lfb_pkg.sv
rtl/lfb_if.sv
rtl/lfb_core.sv
rtl/link_failover_backoff_timer.sv
tb/link_failover_backoff_timer_test.sv
